@@ hw/rtl/pcsrp_pkg.sv @@
// Shared types and constants of the PC sample region profiler.
package pcsrp_pkg;

  localparam int unsigned MAX_REGIONS_DEF = 64;
  localparam int unsigned ADDR_BITS_DEF   = 32;

  // Fixed field widths of the channels
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned RIDX_W    = 6;
  localparam int unsigned RCNT_W    = 7;
  localparam int unsigned CFG_IDX_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROFILING_ON = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 8'd1;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_RDWAIT,
    ST_DONE
  } st_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [RIDX_W-1:0] region_index;
    logic [DATA_W-1:0] region_low;
    logic [DATA_W-1:0] region_high;
    logic [DATA_W-1:0] pc_sample;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] count_read;
    logic              matched;
    logic [RIDX_W-1:0] matched_index;
    logic              lost;
    logic [DATA_W-1:0] sample_total;
    logic [DATA_W-1:0] lost_total;
    logic [DATA_W-1:0] last_lost_address;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    value;
  } cfg_item_t;

endpackage

@@ hw/rtl/pcsrp_chan_if.sv @@
// Valid/ready channel carrying one payload item per transfer.
interface pcsrp_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/pc_sample_region_profiler_unit.sv @@
// PC sample region profiler: address-range histogram walked by one shared comparator.
//
// Sample commands walk the region table one entry per cycle through a single
// low/high range comparator fed from registered-read bound memories, stopping
// at the first region holding the sampled PC or, on a miss, after the last of
// n searched regions (n = region_count, capped at MAX_REGIONS). Loads and
// ignored samples (profiling off or unused command) go straight to the result
// state; reads pass through a wait state for the hit-counter memory read. The
// walk length is set by the one-region-per-cycle memory read port. The input
// is not ready while an item is at work; a finished result sits in the output
// register so the next item can be accepted before it is taken. After reset
// the hit-counter memory is zeroed by a sweep over all MAX_REGIONS entries,
// during which no item is accepted; configuration transfers are always taken.
// Bounds must be loaded before a sample searches them. Addresses compare
// within ADDR_BITS bits.
module pc_sample_region_profiler_unit #(
  parameter int unsigned MAX_REGIONS = pcsrp_pkg::MAX_REGIONS_DEF,
  parameter int unsigned ADDR_BITS   = pcsrp_pkg::ADDR_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  pcsrp_chan_if.sink   in_ch,
  pcsrp_chan_if.source out_ch,
  pcsrp_chan_if.sink   cfg_ch
);
  import pcsrp_pkg::*;

  localparam int unsigned IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int unsigned AW    = (ADDR_BITS < DATA_W) ? ADDR_BITS : DATA_W;

  // Sequencer and walk state
  st_t               state_r, state_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;         // next region to read / clear index
  logic [CNT_W-1:0]  n_r, n_nxt;         // regions to search
  logic              cvld_r, cvld_nxt;   // read data valid for compare
  logic [IDX_W-1:0]  cidx_r, cidx_nxt;   // region under compare
  logic [AW-1:0]     pc_r, pc_nxt;

  // Profiler totals
  logic [DATA_W-1:0] tick_r, tick_nxt;
  logic [DATA_W-1:0] miss_r, miss_nxt;
  logic [AW-1:0]     maddr_r, maddr_nxt;

  // Configuration
  logic              prof_r;
  logic [RCNT_W-1:0] rcnt_r;

  // Result staging and output register
  out_item_t         res_r, res_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Memories
  logic [AW-1:0]     lo_mem  [MAX_REGIONS];
  logic [AW-1:0]     hi_mem  [MAX_REGIONS];
  logic [DATA_W-1:0] hit_mem [MAX_REGIONS];
  logic [AW-1:0]     lo_q, hi_q;
  logic [DATA_W-1:0] cnt_q;

  logic              in_rdy;
  logic [IDX_W-1:0]  rd_addr;
  logic              bnd_we;
  logic              hit_we;
  logic [IDX_W-1:0]  hit_wa;
  logic [DATA_W-1:0] hit_wd;

  logic [DATA_W-1:0] in_idx32;
  logic              idx_ok;
  logic [IDX_W-1:0]  in_addr;
  logic [CNT_W-1:0]  n_calc;
  logic              range_hit;

  assign in_idx32  = DATA_W'(in_ch.data.region_index);
  assign idx_ok    = (in_idx32 < DATA_W'(MAX_REGIONS));
  assign in_addr   = IDX_W'(in_idx32);
  // Region count above the table size searches the whole table
  assign n_calc    = (DATA_W'(rcnt_r) > DATA_W'(MAX_REGIONS)) ? CNT_W'(MAX_REGIONS)
                                                              : CNT_W'(rcnt_r);
  // The shared comparator: inclusive range check
  assign range_hit = (pc_r >= lo_q) && (pc_r <= hi_q);

  assign in_ch.ready  = in_rdy;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
  assign cfg_ch.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prof_r <= 1'b0;
      rcnt_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.idx)
        CFG_PROFILING_ON: prof_r <= cfg_ch.data.value[0];
        CFG_REGION_COUNT: rcnt_r <= cfg_ch.data.value[RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Bound memories
  always_ff @(posedge clk) begin
    if (bnd_we) begin
      lo_mem[in_addr] <= AW'(in_ch.data.region_low);
      hi_mem[in_addr] <= AW'(in_ch.data.region_high);
    end
    lo_q <= lo_mem[rd_addr];
    hi_q <= hi_mem[rd_addr];
  end

  // Hit-counter memory
  always_ff @(posedge clk) begin
    if (hit_we) begin
      hit_mem[hit_wa] <= hit_wd;
    end
    cnt_q <= hit_mem[rd_addr];
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      i_r         <= '0;
      cvld_r      <= 1'b0;
      tick_r      <= '0;
      miss_r      <= '0;
      maddr_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      cvld_r      <= cvld_nxt;
      tick_r      <= tick_nxt;
      miss_r      <= miss_nxt;
      maddr_r     <= maddr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    cidx_r <= cidx_nxt;
    pc_r   <= pc_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    cvld_nxt      = cvld_r;
    cidx_nxt      = cidx_r;
    pc_nxt        = pc_r;
    tick_nxt      = tick_r;
    miss_nxt      = miss_r;
    maddr_nxt     = maddr_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    in_rdy        = 1'b0;
    rd_addr       = i_r[IDX_W-1:0];
    bnd_we        = 1'b0;
    hit_we        = 1'b0;
    hit_wa        = i_r[IDX_W-1:0];
    hit_wd        = '0;

    unique case (state_r)
      ST_CLEAR: begin
        hit_we = 1'b1;
        if (i_r == CNT_W'(MAX_REGIONS - 1)) begin
          i_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          i_nxt = i_r + CNT_W'(1);
        end
      end

      ST_IDLE: begin
        in_rdy  = 1'b1;
        rd_addr = in_addr;
        if (in_ch.valid) begin
          res_nxt.count_read        = '0;
          res_nxt.matched           = 1'b0;
          res_nxt.matched_index     = '0;
          res_nxt.lost              = 1'b0;
          res_nxt.sample_total      = tick_r;
          res_nxt.lost_total        = miss_r;
          res_nxt.last_lost_address = DATA_W'(maddr_r);
          state_nxt                 = ST_DONE;
          case (in_ch.data.cmd)
            CMD_LOAD: bnd_we = idx_ok;
            CMD_SAMPLE: begin
              if (prof_r) begin
                tick_nxt             = tick_r + 32'd1;
                res_nxt.sample_total = tick_r + 32'd1;
                if (n_calc == '0) begin
                  // empty table: the sample is lost at once
                  miss_nxt                  = miss_r + 32'd1;
                  maddr_nxt                 = AW'(in_ch.data.pc_sample);
                  res_nxt.lost              = 1'b1;
                  res_nxt.lost_total        = miss_r + 32'd1;
                  res_nxt.last_lost_address = DATA_W'(AW'(in_ch.data.pc_sample));
                end else begin
                  n_nxt     = n_calc;
                  i_nxt     = '0;
                  cvld_nxt  = 1'b0;
                  pc_nxt    = AW'(in_ch.data.pc_sample);
                  state_nxt = ST_WALK;
                end
              end
            end
            CMD_READ: begin
              if (idx_ok) begin
                state_nxt = ST_RDWAIT;
              end
            end
            default: ;
          endcase
        end
      end

      ST_WALK: begin
        // issue one region read per cycle, compare the previous one
        cvld_nxt = (i_r < n_r);
        cidx_nxt = i_r[IDX_W-1:0];
        if (i_r < n_r) begin
          i_nxt = i_r + CNT_W'(1);
        end
        if (cvld_r) begin
          if (range_hit) begin
            hit_we                = 1'b1;
            hit_wa                = cidx_r;
            hit_wd                = cnt_q + 32'd1;
            res_nxt.matched       = 1'b1;
            res_nxt.matched_index = RIDX_W'(cidx_r);
            state_nxt             = ST_DONE;
          end else if (CNT_W'(cidx_r) + CNT_W'(1) == n_r) begin
            miss_nxt                  = miss_r + 32'd1;
            maddr_nxt                 = pc_r;
            res_nxt.lost              = 1'b1;
            res_nxt.lost_total        = miss_r + 32'd1;
            res_nxt.last_lost_address = DATA_W'(pc_r);
            state_nxt                 = ST_DONE;
          end
        end
      end

      ST_RDWAIT: begin
        res_nxt.count_read = cnt_q;
        state_nxt          = ST_DONE;
      end

      ST_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ bench/pc_sample_region_profiler_unit_tb.sv @@
// Self-checking testbench for the PC sample region profiler: directed and random traffic.
module pc_sample_region_profiler_unit_tb;
  import pcsrp_pkg::*;

  localparam int NREG        = MAX_REGIONS_DEF;
  localparam int SETTLE      = 8;     // idle cycles before a register write
  localparam int TAIL_CYCLES = 80;    // longer than the slowest walk
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int QUIET_LIMIT = 4000;  // cycles with no transfer at all

  logic clk;
  logic rst_n;

  pcsrp_chan_if #(.T(in_item_t))  in_ch ();
  pcsrp_chan_if #(.T(out_item_t)) out_ch ();
  pcsrp_chan_if #(.T(cfg_item_t)) cfg_ch ();

  pc_sample_region_profiler_unit uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Histogram predictor state, updated at each accepted transfer
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] tbl_lo [NREG];
  logic [DATA_W-1:0] tbl_hi [NREG];
  logic [DATA_W-1:0] hits   [NREG];
  logic [DATA_W-1:0] ticks;
  logic [DATA_W-1:0] misses;
  logic [DATA_W-1:0] miss_pc;
  logic              prof_on;
  logic [RCNT_W-1:0] region_cnt;

  out_item_t due_results [$];   // expected results, oldest first
  in_item_t  pending_items [$]; // stimulus waiting for the driver

  // Stimulus-side view of the region table, in queue order, used to aim samples
  logic [DATA_W-1:0] plan_lo [NREG];
  logic [DATA_W-1:0] plan_hi [NREG];
  int                plan_count = 0;

  int  tx_idle_pct  = 0;
  int  rx_stall_pct = 0;
  int  rx_hold_asks = 0;   // bumped by the stimulus to request a long hold-off
  int  rx_hold_done = 0;
  int  rx_hold_left = 0;
  bit  in_fire      = 1'b0;
  int  quiet        = 0;
  int  mismatches   = 0;

  // One item through the histogram: returns the result it must produce.
  function automatic out_item_t histogram_step(input in_item_t it);
    out_item_t r;
    int        n;
    r = '0;
    case (it.cmd)
      CMD_LOAD: begin
        tbl_lo[it.region_index] = it.region_low;
        tbl_hi[it.region_index] = it.region_high;
      end
      CMD_SAMPLE: begin
        if (prof_on) begin
          // a count above the table size searches the whole table
          n = (region_cnt > NREG) ? NREG : region_cnt;
          ticks++;
          // first region holding the PC wins; inverted bounds never match
          for (int i = 0; i < n; i++) begin
            if (!r.matched && it.pc_sample >= tbl_lo[i] && it.pc_sample <= tbl_hi[i]) begin
              hits[i]++;
              r.matched       = 1'b1;
              r.matched_index = RIDX_W'(i);
            end
          end
          if (!r.matched) begin
            miss_pc = it.pc_sample;
            misses++;
            r.lost = 1'b1;
          end
        end
      end
      CMD_READ: r.count_read = hits[it.region_index];
      default: ;  // unused command: totals only
    endcase
    r.sample_total      = ticks;
    r.lost_total        = misses;
    r.last_lost_address = miss_pc;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Input driver: presents the next pending item at the falling edge once the
  // current one has transferred; valid never drops while an item is offered.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_items.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
        in_ch.data  <= pending_items.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, plus a long hold-off on request so the
  // block backs up and stalls its input while the driver keeps offering.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (rx_hold_done != rx_hold_asks) begin
      rx_hold_done <= rx_hold_asks;
      rx_hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: all transfers are sampled at the rising edge. Register writes and
  // input items feed the predictor; each result is checked against the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.idx)
          CFG_PROFILING_ON: prof_on    = cfg_ch.data.value[0];
          CFG_REGION_COUNT: region_cnt = cfg_ch.data.value[RCNT_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        due_results.push_back(histogram_step(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, actual %h", $time, got);
        end else begin
          want = due_results.pop_front();
          check_field("count_read",        want.count_read,        got.count_read);
          check_field("matched",           DATA_W'(want.matched),  DATA_W'(got.matched));
          check_field("matched_index",     DATA_W'(want.matched_index),
                      DATA_W'(got.matched_index));
          check_field("lost",              DATA_W'(want.lost),     DATA_W'(got.lost));
          check_field("sample_total",      want.sample_total,      got.sample_total);
          check_field("lost_total",        want.lost_total,        got.lost_total);
          check_field("last_lost_address", want.last_lost_address, got.last_lost_address);
        end
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress. Covers the
  // clearing sweep after reset, the long hold-off and the slowest walks.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input cmd_t cmd, input logic [RIDX_W-1:0] idx,
                            input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                            input logic [DATA_W-1:0] pc);
    in_item_t it;
    it.cmd          = cmd;
    it.region_index = idx;
    it.region_low   = lo;
    it.region_high  = hi;
    it.pc_sample    = pc;
    if (cmd == CMD_LOAD) begin
      plan_lo[idx] = lo;
      plan_hi[idx] = hi;
    end
    pending_items.push_back(it);
  endtask

  // Region shapes: mostly narrow spans, some single addresses, inverted
  // bounds, regions hugging either end of the space; the whole space only in
  // late entries so deep matches stay common.
  function automatic void pick_bounds(input int idx, output logic [DATA_W-1:0] lo,
                                      output logic [DATA_W-1:0] hi);
    int              sel;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W:0]   top;
    sel = $urandom_range(99, 0);
    a   = $urandom;
    b   = $urandom;
    if (sel < 60) begin
      lo  = a;
      top = {1'b0, a} + (b >> $urandom_range(31, 12));
      hi  = top[DATA_W] ? '1 : top[DATA_W-1:0];
    end else if (sel < 70) begin
      lo = a;
      hi = a;
    end else if (sel < 80) begin
      lo = (a > b) ? a : b;
      hi = (a > b) ? b : a;
    end else if (sel < 88) begin
      lo = '0;
      hi = b >> $urandom_range(31, 8);
    end else if (sel < 96 || idx < 48) begin
      lo = ~(b >> $urandom_range(31, 8));
      hi = '1;
    end else begin
      lo = '0;
      hi = '1;
    end
  endfunction

  // Sample address: inside a searched region, on or just past its edges,
  // anywhere, or at the ends of the address space.
  function automatic logic [DATA_W-1:0] pick_pc();
    int                j;
    int                sel;
    int                reach;
    longint unsigned   span;
    longint unsigned   r;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    reach = (plan_count == 0 || plan_count > NREG) ? NREG : plan_count;
    j     = $urandom_range(reach - 1, 0);
    lo    = plan_lo[j];
    hi    = plan_hi[j];
    sel   = $urandom_range(99, 0);
    if (sel < 55 && lo <= hi) begin
      span = {32'b0, hi} - {32'b0, lo} + 64'd1;
      r    = {$urandom, $urandom};
      return lo + DATA_W'(r % span);
    end
    if (sel < 75) begin
      case ($urandom_range(3, 0))
        0:       return lo;
        1:       return hi;
        2:       return lo - 1;
        default: return hi + 1;
      endcase
    end
    if (sel < 95) return $urandom;
    return sel[0] ? '1 : '0;
  endfunction

  // Mostly samples, with loads that reshape the table as the run goes on.
  task automatic queue_random(input int n);
    int                sel;
    logic [RIDX_W-1:0] idx;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    repeat (n) begin
      sel = $urandom_range(99, 0);
      idx = RIDX_W'($urandom_range(NREG - 1, 0));
      lo  = $urandom;
      hi  = $urandom;
      if (sel < 15) begin
        pick_bounds(idx, lo, hi);
        queue_item(CMD_LOAD, idx, lo, hi, $urandom);
      end else if (sel < 75) begin
        queue_item(CMD_SAMPLE, idx, lo, hi, pick_pc());
      end else if (sel < 95) begin
        queue_item(CMD_READ, idx, lo, hi, $urandom);
      end else begin
        queue_item(CMD_NOP, idx, lo, hi, $urandom);
      end
    end
  endtask

  // Block is idle once the driver is empty and every result has come back.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_ch.valid || due_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_item_t w;
    w.idx   = idx;
    w.value = val;
    @(negedge clk);
    cfg_ch.data  <= w;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(input bit prof, input int cnt);
    wait_idle();
    write_reg(CFG_PROFILING_ON, DATA_W'(prof));
    write_reg(CFG_REGION_COUNT, cnt);
    plan_count = cnt;
  endtask

  task automatic run_phase(input bit prof, input int cnt, input int tx_pct,
                           input int rx_pct, input int n);
    configure(prof, cnt);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    queue_random(n);
  endtask

  // ---------------------------------------------------------------------------
  // Reset, directed part, random phases, end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [DATA_W-1:0] fill_lo;
    logic [DATA_W-1:0] fill_hi;

    foreach (hits[i]) begin
      hits[i]   = '0;
      tbl_lo[i] = '0;
      tbl_hi[i] = '0;
      plan_lo[i] = '0;
      plan_hi[i] = '0;
    end
    ticks      = '0;
    misses     = '0;
    miss_pc    = '0;
    prof_on    = 1'b0;
    region_cnt = '0;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: profiling off, nothing searched, counters zero.
    queue_item(CMD_NOP, '1, '1, '1, '1);
    queue_item(CMD_READ, '0, '0, '0, '0);
    queue_item(CMD_READ, RIDX_W'(NREG - 1), '0, '0, '0);
    queue_item(CMD_SAMPLE, '0, '0, '0, '1);             // profiling off: ignored
    queue_item(CMD_LOAD, '0, 32'h0000_1000, 32'h0000_1fff, '0);
    queue_item(CMD_LOAD, RIDX_W'(1), 32'h0000_3000, 32'h0000_2000, '0);  // inverted
    queue_item(CMD_LOAD, RIDX_W'(2), '1, '1, '0);       // top address only

    // Zero regions searched: every counted sample is lost.
    configure(1'b1, 0);
    queue_item(CMD_SAMPLE, '0, '0, '0, '0);
    queue_item(CMD_SAMPLE, '0, '0, '0, '1);

    // Three regions: bounds are inclusive, inverted region never matches.
    configure(1'b1, 3);
    queue_item(CMD_SAMPLE, '0, '0, '0, 32'h0000_1000);
    queue_item(CMD_SAMPLE, '0, '0, '0, 32'h0000_1fff);
    queue_item(CMD_SAMPLE, '0, '0, '0, 32'h0000_0fff);
    queue_item(CMD_SAMPLE, '0, '0, '0, 32'h0000_2000);
    queue_item(CMD_SAMPLE, '0, '0, '0, 32'h0000_2800);
    queue_item(CMD_SAMPLE, '0, '0, '0, '1);
    queue_item(CMD_READ, '0, '0, '0, '0);
    queue_item(CMD_READ, RIDX_W'(2), '0, '0, '0);

    // Fill the whole table so any region count is legal from here on;
    // the last entry spans the whole address space.
    for (int i = 0; i < NREG - 1; i++) begin
      pick_bounds(i, fill_lo, fill_hi);
      queue_item(CMD_LOAD, RIDX_W'(i), fill_lo, fill_hi, $urandom);
    end
    queue_item(CMD_LOAD, RIDX_W'(NREG - 1), '0, '1, $urandom);

    // Full table, no idling, then a long hold-off on the result side.
    run_phase(1'b1, NREG, 0, 0, 40);
    rx_hold_asks++;

    // Sender idling, with a pause mid-phase until all results are back.
    run_phase(1'b1, 8, 60, 0, 20);
    wait_idle();
    queue_random(20);

    run_phase(1'b1, $urandom_range(NREG - 1, 1), 0, 60, 40);
    run_phase(1'b1, 127, 31, 31, 40);                    // count beyond the table
    run_phase(1'b0, 20, 0, 0, 25);                       // profiling off
    run_phase(1'b1, 0, 0, 60, 25);                       // nothing searched
    run_phase(1'b1, $urandom_range(126, NREG + 1), 31, 31, 40);
    run_phase(1'b1, 1, 60, 0, 35);
    run_phase(1'b1, NREG, 0, 0, 35);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
